[src/deq_pkg.sv]
// ============================================================================
// deq_pkg
// Shared types and constants for the double-ended queue: operation codes,
// status codes and fixed field widths.
// ============================================================================
`default_nettype none

package deq_pkg;

   // fixed field widths
   localparam int WORD_W   = 64;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   // operation codes; 6 and 7 behave as a query
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_BACK  = 3'd0,
      FUNC_PUSH_FRONT = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_REVERSE    = 3'd4,
      FUNC_QUERY      = 3'd5
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage : deq_pkg

`default_nettype wire

[src/double_ended_queue.sv]
// ============================================================================
// double_ended_queue
// Bounded deque of 64-bit words in a ring store with one write and one read
// port. Front and back words are kept in registers; a pop fetches the new end
// word from the ring, and reversal flips a direction bit.
// ============================================================================
// Timing: a request passes an input register, then an execute stage that
//   updates state and ring and registers the result strobe.
// Throughput: one request per cycle, busy stays low; set by the single ring
//   read port, whose registered data is forwarded to the next request.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears head, count, direction and strobes; ring words are not cleared.
`default_nettype none

module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [FUNC_W-1:0]            req_func,
   input  wire  [WORD_W-1:0]            req_value,
   output logic                         rsp_valid,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [WORD_W-1:0]            rsp_front_value,
   output logic [WORD_W-1:0]            rsp_back_value,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_count,
   output logic                         rsp_is_empty
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 2;

   // ring index helpers
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - 1'b1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] r;
      r = (x >= SUM_W'(DEPTH)) ? SUM_W'(x - SUM_W'(DEPTH)) : x;
      return r[IDX_W-1:0];
   endfunction

   // input register
   logic                 req_valid_ff;
   func_type             func_ff;
   logic [WORD_W-1:0]    value_ff;

   // deque state
   logic [IDX_W-1:0]     head_ff,     head_in;
   logic [CNT_W-1:0]     count_ff,    count_in;
   logic                 rev_ff,      rev_in;
   logic [WORD_W-1:0]    first_ff,    first_in;
   logic [WORD_W-1:0]    last_ff,     last_in;
   logic                 first_rd_ff, first_rd_in;
   logic                 last_rd_ff,  last_rd_in;

   // ring store and its read register
   logic [WORD_W-1:0]    ring_mem [DEPTH];
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;

   // result register
   logic                 rsp_valid_ff;
   status_type           status_ff, status_in;

   // execute-stage views
   logic                 is_empty;
   logic                 is_full;
   logic [WORD_W-1:0]    first_cur;
   logic [WORD_W-1:0]    last_cur;
   logic [SUM_W-1:0]     end_sum;
   logic [IDX_W-1:0]     tail_idx;

   // every request is taken the cycle it is offered
   assign busy = 1'b0;

   // capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
      func_ff  <= func_type'(req_func);
      value_ff <= req_value;
   end

   // end words, with forwarding of the last ring read
   assign first_cur = first_rd_ff ? rd_data_ff : first_ff;
   assign last_cur  = last_rd_ff  ? rd_data_ff : last_ff;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign end_sum   = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx  = ring_wrap(SUM_W'(end_sum - SUM_W'(1)));

   // operation decode and next state
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      rev_in      = rev_ff;
      first_in    = first_cur;
      last_in     = last_cur;
      first_rd_in = 1'b0;
      last_rd_in  = 1'b0;
      status_in   = STATUS_OK;
      wr_en       = 1'b0;
      wr_addr     = ring_wrap(end_sum);
      rd_en       = 1'b0;
      rd_addr     = ring_next(head_ff);
      case (func_ff)
         FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = CNT_W'(count_ff + 1'b1);
               if ((func_ff == FUNC_PUSH_FRONT) ^ rev_ff) begin
                  head_in  = ring_prev(head_ff);
                  wr_addr  = ring_prev(head_ff);
                  first_in = value_ff;
                  if (is_empty) last_in = value_ff;
               end else begin
                  last_in = value_ff;
                  if (is_empty) first_in = value_ff;
               end
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en    = 1'b1;
               count_in = CNT_W'(count_ff - 1'b1);
               if ((func_ff == FUNC_POP_FRONT) ^ rev_ff) begin
                  head_in     = ring_next(head_ff);
                  first_rd_in = 1'b1;
               end else begin
                  rd_addr    = ring_prev(tail_idx);
                  last_rd_in = 1'b1;
               end
            end
         end
         FUNC_REVERSE: begin
            if (is_empty) status_in = STATUS_EMPTY;
            else          rev_in    = ~rev_ff;
         end
         default: begin
         end
      endcase
   end

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         first_rd_ff  <= 1'b0;
         last_rd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            head_ff     <= head_in;
            count_ff    <= count_in;
            rev_ff      <= rev_in;
            first_rd_ff <= first_rd_in;
            last_rd_ff  <= last_rd_in;
         end
      end
      if (req_valid_ff) begin
         first_ff  <= first_in;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

   // ring store: one write, one registered read
   always_ff @(posedge clock) begin
      if (req_valid_ff && wr_en) ring_mem[wr_addr] <= value_ff;
      if (req_valid_ff && rd_en) rd_data_ff <= ring_mem[rd_addr];
   end

   // result ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_front_value = is_empty ? '0 : (rev_ff ? last_cur : first_cur);
   assign rsp_back_value  = is_empty ? '0 : (rev_ff ? first_cur : last_cur);
   assign rsp_count       = count_ff;
   assign rsp_is_empty    = is_empty;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_refused_no_change: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && status_in != STATUS_OK) |=>
         ($stable(count_ff) && $stable(head_ff) && $stable(rev_ff)))
      else $error("refused request changed state");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_FULL) |-> (count_ff == CNT_W'(DEPTH)))
      else $error("full status while not full");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rd_en) |=> (count_ff == CNT_W'($past(count_ff) - 1'b1)))
      else $error("pop did not decrement count");

endmodule : double_ended_queue

`default_nettype wire

[bench/tb_top.sv]
// ============================================================================
// tb_top: self-checking bench for the double-ended queue
// Drives push, pop, reverse and query requests in random bursts, predicts
// each result from a behavioral copy of the ring, head index, entry count and
// direction bit, and compares every result strobe field by field.
// ============================================================================
`default_nettype none

module tb_top
   import deq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = 16;
   localparam int CNT_W         = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS  = 600;
   localparam int IDLE_LIMIT    = 1000;
   localparam int TAIL_CYCLES   = 10;
   localparam int REPORT_LIMIT  = 50;

   // spare codes, handled as a query
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   // stimulus mix per segment
   localparam int MIX_FILL    = 0;
   localparam int MIX_DRAIN   = 1;
   localparam int MIX_BALANCE = 2;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [WORD_W-1:0] value;
      logic              hold_for_idle;
   } deq_request_type;

   typedef struct {
      status_type        status;
      logic [WORD_W-1:0] front_value;
      logic [WORD_W-1:0] back_value;
      logic [CNT_W-1:0]  count;
      logic              is_empty;
   } deq_result_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic [FUNC_W-1:0]    req_func  = FUNC_QUERY;
   logic [WORD_W-1:0]    req_value = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [WORD_W-1:0]    rsp_front_value;
   logic [WORD_W-1:0]    rsp_back_value;
   logic [CNT_W-1:0]     rsp_count;
   logic                 rsp_is_empty;

   deq_request_type pending_q[$];
   deq_result_type  expected_q[$];

   int sent_count     = 0;
   int rcvd_count     = 0;
   int mismatch_count = 0;
   int idle_cycles    = 0;
   int burst_left     = 0;
   int gap_left       = 0;

   // shadow deque state
   logic [WORD_W-1:0] shadow_ring[DEPTH];
   int                shadow_head    = 0;
   int                shadow_count   = 0;
   logic              shadow_flipped = 1'b0;

   double_ended_queue #(.DEPTH(DEPTH)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // apply one request to the shadow deque and return the result it causes
   function automatic deq_result_type apply_deq_op(input logic [FUNC_W-1:0] func,
                                                   input logic [WORD_W-1:0] value);
      deq_result_type r;
      logic        at_first;
      logic [WORD_W-1:0] first_word;
      logic [WORD_W-1:0] last_word;
      r.status   = STATUS_OK;
      first_word = '0;
      last_word  = '0;
      case (func)
         FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
            if (shadow_count == DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               at_first = (func == FUNC_PUSH_FRONT) ^ shadow_flipped;
               if (at_first) begin
                  shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                  shadow_ring[shadow_head] = value;
               end else begin
                  shadow_ring[(shadow_head + shadow_count) % DEPTH] = value;
               end
               shadow_count++;
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               at_first = (func == FUNC_POP_FRONT) ^ shadow_flipped;
               if (at_first) shadow_head = (shadow_head + 1) % DEPTH;
               shadow_count--;
            end
         end
         FUNC_REVERSE: begin
            // reversing one entry still flips the direction bit
            if (shadow_count == 0) r.status = STATUS_EMPTY;
            else shadow_flipped = ~shadow_flipped;
         end
         default: ;  // query and spare codes leave state alone
      endcase
      if (shadow_count != 0) begin
         first_word = shadow_ring[shadow_head];
         last_word  = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
      end
      r.front_value = shadow_flipped ? last_word : first_word;
      r.back_value  = shadow_flipped ? first_word : last_word;
      r.count       = CNT_W'(shadow_count);
      r.is_empty    = (shadow_count == 0);
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return {$urandom(), $urandom()};
   endfunction

   // choose an operation according to the segment mix
   function automatic logic [FUNC_W-1:0] rand_func(input int mix);
      int pick;
      int push_pct;
      int pop_pct;
      pick     = $urandom_range(0, 99);
      push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 15 : 40;
      pop_pct  = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 70 : 40;
      if (pick < push_pct)
         return $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      if (pick < push_pct + pop_pct)
         return $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
      if (pick < push_pct + pop_pct + 9) return FUNC_REVERSE;
      if (pick < push_pct + pop_pct + 13) return FUNC_QUERY;
      return $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
   endfunction

   task automatic add_request(input logic [FUNC_W-1:0] func,
                              input logic [WORD_W-1:0] value,
                              input logic              hold_for_idle);
      deq_request_type item;
      item.func          = func;
      item.value         = value;
      item.hold_for_idle = hold_for_idle;
      pending_q.push_back(item);
   endtask

   // driver: presents requests in bursts, predicts on acceptance
   always @(posedge clock) begin : drive_proc
      logic fire;
      if (reset) begin
         start <= 1'b0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            expected_q.push_back(apply_deq_op(req_func, req_value));
            sent_count++;
         end
         if (fire || !start) begin
            if (gap_left != 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_q.size() == 0) begin
               start <= 1'b0;
            end else if (pending_q[0].hold_for_idle && sent_count != rcvd_count) begin
               // wait until every outstanding result has come back
               start <= 1'b0;
            end else begin
               start     <= 1'b1;
               req_func  <= pending_q[0].func;
               req_value <= pending_q[0].value;
               void'(pending_q.pop_front());
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // monitor: check each result strobe against the oldest prediction
   always @(posedge clock) begin : check_proc
      deq_result_type want;
      if (!reset && rsp_valid) begin
         rcvd_count <= rcvd_count + 1;
         if (expected_q.size() == 0) begin
            report_mismatch("result strobe with no request outstanding");
         end else begin
            want = expected_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_front_value !== want.front_value)
               report_mismatch($sformatf("front_value %h, want %h",
                                         rsp_front_value, want.front_value));
            if (rsp_back_value !== want.back_value)
               report_mismatch($sformatf("back_value %h, want %h",
                                         rsp_back_value, want.back_value));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("count %0d, want %0d", rsp_count, want.count));
            if (rsp_is_empty !== want.is_empty)
               report_mismatch($sformatf("is_empty %b, want %b",
                                         rsp_is_empty, want.is_empty));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin : watchdog_proc
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("timeout: no request or result for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin : stim_proc
      int n;
      int k;
      int mix;
      int seg_len;
      logic hold;

      // directed: empty-deque refusals, single-entry reverse, extremes, spare codes
      add_request(FUNC_QUERY,      rand_word(),      1'b0);
      add_request(FUNC_POP_FRONT,  rand_word(),      1'b0);
      add_request(FUNC_POP_BACK,   rand_word(),      1'b0);
      add_request(FUNC_REVERSE,    rand_word(),      1'b0);
      add_request(FUNC_PUSH_BACK,  '0,               1'b0);
      add_request(FUNC_REVERSE,    rand_word(),      1'b0);
      add_request(FUNC_SPARE_LO,   rand_word(),      1'b0);
      add_request(FUNC_SPARE_HI,   rand_word(),      1'b0);
      add_request(FUNC_PUSH_FRONT, '1,               1'b0);
      add_request(FUNC_PUSH_BACK,  64'h5555_5555_5555_5555, 1'b0);
      add_request(FUNC_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      add_request(FUNC_REVERSE,    rand_word(),      1'b0);
      add_request(FUNC_QUERY,      rand_word(),      1'b0);
      add_request(FUNC_POP_FRONT,  rand_word(),      1'b0);
      add_request(FUNC_POP_BACK,   rand_word(),      1'b0);
      add_request(FUNC_REVERSE,    rand_word(),      1'b0);
      add_request(FUNC_POP_BACK,   rand_word(),      1'b0);
      add_request(FUNC_POP_FRONT,  rand_word(),      1'b0);
      add_request(FUNC_POP_FRONT,  rand_word(),      1'b0);
      add_request(FUNC_REVERSE,    rand_word(),      1'b0);

      // random: segments that lean toward filling, draining or neither
      n = 0;
      while (n < RANDOM_ITEMS) begin
         mix     = $urandom_range(MIX_FILL, MIX_BALANCE);
         seg_len = $urandom_range(15, 50);
         hold    = (n == 0) || ($urandom_range(0, 3) == 0);
         for (k = 0; k < seg_len; k++) begin
            add_request(rand_func(mix), rand_word(), hold && (k == 0));
            n++;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || start || sent_count != rcvd_count)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (expected_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule : tb_top

`default_nettype wire

[sim.f]
src/deq_pkg.sv
src/double_ended_queue.sv
bench/tb_top.sv
